// File: rtl/core/bmmrs_pkg.sv
// Shared types and constants for the block min/max/RMS summary core.
// Used by bmmrs_divsqrt and block_min_max_rms_summary_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmmrs_pkg;

   localparam int SAMPLE_BITS_DEF = 24;

   // Accumulator and root datapath widths
   localparam int SUM_BITS   = 64;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int REM_BITS   = ROOT_BITS + 2;
   localparam int COUNT_BITS = 17;
   localparam int BLK_BITS   = 16;
   localparam int STEP_BITS  = 6;

   localparam logic [COUNT_BITS-1:0] SMALL_BLOCK = COUNT_BITS'(256);
   localparam logic [COUNT_BITS-1:0] LARGE_BLOCK = COUNT_BITS'(64 * 1024);

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SQUARE,
      SEQ_ACCUM,
      SEQ_ROOT,
      SEQ_RESULT
   } seq_state_type;

   typedef enum logic [1:0] {
      DSQ_IDLE,
      DSQ_DIV,
      DSQ_ROOT,
      DSQ_DONE
   } dsq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dsq_status_type;

endpackage

`default_nettype wire

// File: rtl/core/bmmrs_divsqrt.sv
// Bit-serial divide followed by bit-serial integer square root on one subtractor.
// Depends on bmmrs_pkg for widths, the state type and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module bmmrs_divsqrt
   import bmmrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [SUM_BITS-1:0]   dividend,
   input  wire logic [COUNT_BITS-1:0] divisor,
   output dsq_status_type             status,
   output logic [ROOT_BITS-1:0]       root
);

   dsq_state_type               state_ff, state_in;
   logic [SUM_BITS-1:0]         work_ff, work_in;
   logic [REM_BITS-1:0]         rem_ff, rem_in;
   logic [ROOT_BITS-1:0]        root_ff, root_in;
   logic [COUNT_BITS-1:0]       divisor_ff, divisor_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;

   logic [REM_BITS-1:0]         op_a;
   logic [REM_BITS-1:0]         op_b;
   logic [REM_BITS:0]           diff;
   logic                        fit;

   // Shared subtractor: restoring division in DIV, digit recurrence in ROOT
   always_comb begin
      if (state_ff == DSQ_ROOT) begin
         op_a = {rem_ff[ROOT_BITS-1:0], work_ff[SUM_BITS-1 -: 2]};
         op_b = {root_ff, 2'b01};
      end else begin
         op_a = REM_BITS'({rem_ff[COUNT_BITS-1:0], work_ff[SUM_BITS-1]});
         op_b = REM_BITS'(divisor_ff);
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      fit  = ~diff[REM_BITS];
   end

   always_comb begin
      state_in   = state_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      status     = '{busy: (state_ff != DSQ_IDLE), done: 1'b0};
      case (state_ff)
         DSQ_IDLE: begin
            if (start) begin
               work_in    = dividend;
               divisor_in = divisor;
               rem_in     = '0;
               step_in    = STEP_BITS'(SUM_BITS - 1);
               state_in   = DSQ_DIV;
            end
         end
         DSQ_DIV: begin
            work_in = {work_ff[SUM_BITS-2:0], fit};
            rem_in  = fit ? diff[REM_BITS-1:0] : op_a;
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_BITS'(ROOT_BITS - 1);
               state_in = DSQ_ROOT;
            end
         end
         DSQ_ROOT: begin
            work_in = {work_ff[SUM_BITS-3:0], 2'b00};
            rem_in  = fit ? diff[REM_BITS-1:0] : op_a;
            root_in = {root_ff[ROOT_BITS-2:0], fit};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = DSQ_DONE;
            end
         end
         DSQ_DONE: begin
            status.done = 1'b1;
            state_in    = DSQ_IDLE;
         end
         default: begin
            state_in = DSQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DSQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   assign root = root_ff;

endmodule

`default_nettype wire

// File: rtl/core/block_min_max_rms_summary_core.sv
// Top level of the block min/max/RMS summary core: accumulators, sequencer, ports.
// Depends on bmmrs_pkg and instantiates bmmrs_divsqrt for the mean-square root.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Carries
// --------+-----------+--------------------------------------------------------
// req_    | in        | tdata: sample; tlast: end_of_buffer; tuser: restart
// rsp_    | out       | tdata: min, max, rms, block_number; tuser: is_partial
// csr_    | in        | data: summary_mode (0: 256-sample, 1: 65536-sample blocks)
//
// A sample that emits no summary passes through latch, square on the multiplier and
// accumulate before the next accept. A sample that closes a block or marks end of
// buffer also waits for the shared subtractor, which runs 64 divide steps and then
// 32 square-root steps, one bit per cycle.
// Reset is synchronous and active high; it returns mode and accumulators to
// their initial values. The summary sits in an output register, so a stalled
// rsp_ channel holds only the next summary, not samples that emit none.

module block_min_max_rms_summary_core
   import bmmrs_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request transaction
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                          req_tdata,  // [SAMPLE_BITS-1:0] sample
   input  wire logic                      req_tlast,  // end_of_buffer
   input  wire logic                      req_tuser,  // restart
   // response transaction
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [((3 * SAMPLE_BITS + BLK_BITS + 7) / 8) * 8 - 1:0]
                                          rsp_tdata,  // min, max, rms, block_number
   output logic                           rsp_tuser,  // is_partial
   // configuration write
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_data    // summary_mode
);

   localparam int RSP_TDATA_BITS = ((3 * SAMPLE_BITS + BLK_BITS + 7) / 8) * 8;
   localparam int SQ_BITS        = 2 * SAMPLE_BITS;

   localparam logic signed [SAMPLE_BITS-1:0] MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MAX_INIT = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   seq_state_type                   state_ff, state_in;
   logic                            mode_ff, mode_in;

   // held request transaction
   logic signed [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic                            eob_ff, eob_in;
   logic [SQ_BITS-1:0]              sq_ff, sq_in;

   // block accumulators
   logic signed [SAMPLE_BITS-1:0]   min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0]   max_ff, max_in;
   logic [SUM_BITS-1:0]             sum_ff, sum_in;
   logic [COUNT_BITS-1:0]           count_ff, count_in;
   logic [BLK_BITS-1:0]             blk_ff, blk_in;

   // summary snapshot while the root runs, then the output register
   logic signed [SAMPLE_BITS-1:0]   snap_min_ff, snap_min_in;
   logic signed [SAMPLE_BITS-1:0]   snap_max_ff, snap_max_in;
   logic [BLK_BITS-1:0]             snap_blk_ff, snap_blk_in;
   logic                            snap_partial_ff, snap_partial_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0]   rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_BITS-1:0]   rsp_max_ff, rsp_max_in;
   logic [SAMPLE_BITS-1:0]          rsp_rms_ff, rsp_rms_in;
   logic [BLK_BITS-1:0]             rsp_blk_ff, rsp_blk_in;
   logic                            rsp_partial_ff, rsp_partial_in;

   logic [SAMPLE_BITS-1:0]          mag;
   logic [SUM_BITS:0]               sum_add;
   logic [SUM_BITS-1:0]             sum_next;
   logic [COUNT_BITS-1:0]           limit;
   logic                            full;

   logic                            dsq_start;
   logic [SUM_BITS-1:0]             dsq_dividend;
   dsq_status_type                  dsq_status;
   logic [ROOT_BITS-1:0]            dsq_root;

   // Magnitude of the most negative sample still fits as unsigned
   assign mag = sample_ff[SAMPLE_BITS-1] ? (~sample_ff + SAMPLE_BITS'(1)) : sample_ff;

   // Saturate the sum of squares at all ones
   assign sum_add  = {1'b0, sum_ff} + (SUM_BITS + 1)'(sq_ff);
   assign sum_next = sum_add[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_add[SUM_BITS-1:0];

   assign limit = mode_ff ? LARGE_BLOCK : SMALL_BLOCK;
   assign full  = (count_ff >= limit);

   assign req_tready = (state_ff == SEQ_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      sample_in       = sample_ff;
      eob_in          = eob_ff;
      sq_in           = sq_ff;
      min_in          = min_ff;
      max_in          = max_ff;
      sum_in          = sum_ff;
      count_in        = count_ff;
      blk_in          = blk_ff;
      snap_min_in     = snap_min_ff;
      snap_max_in     = snap_max_ff;
      snap_blk_in     = snap_blk_ff;
      snap_partial_in = snap_partial_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_min_in      = rsp_min_ff;
      rsp_max_in      = rsp_max_ff;
      rsp_rms_in      = rsp_rms_ff;
      rsp_blk_in      = rsp_blk_ff;
      rsp_partial_in  = rsp_partial_ff;
      dsq_start       = 1'b0;
      dsq_dividend    = sum_next;

      // Drop the response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // A mode change starts over from an empty first block
      if (csr_valid && (csr_data != mode_ff)) begin
         mode_in  = csr_data;
         min_in   = MIN_INIT;
         max_in   = MAX_INIT;
         sum_in   = '0;
         count_in = '0;
         blk_in   = '0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               eob_in    = req_tlast;
               // Restart clears everything before this sample counts
               if (req_tuser) begin
                  min_in   = MIN_INIT;
                  max_in   = MAX_INIT;
                  sum_in   = '0;
                  count_in = '0;
                  blk_in   = '0;
               end
               state_in = SEQ_SQUARE;
            end
         end
         SEQ_SQUARE: begin
            sq_in = SQ_BITS'(mag) * SQ_BITS'(mag);
            if (sample_ff < min_ff) begin
               min_in = sample_ff;
            end
            if (sample_ff > max_ff) begin
               max_in = sample_ff;
            end
            count_in = count_ff + COUNT_BITS'(1);
            state_in = SEQ_ACCUM;
         end
         SEQ_ACCUM: begin
            sum_in = sum_next;
            if (full || eob_ff) begin
               // Snapshot the summary, hand sum and count to the root unit
               snap_min_in     = min_ff;
               snap_max_in     = max_ff;
               snap_blk_in     = blk_ff;
               snap_partial_in = ~full;
               dsq_start       = 1'b1;
               if (full) begin
                  min_in   = MIN_INIT;
                  max_in   = MAX_INIT;
                  sum_in   = '0;
                  count_in = '0;
                  blk_in   = blk_ff + BLK_BITS'(1);
               end
               state_in = SEQ_ROOT;
            end else begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_ROOT: begin
            if (dsq_status.done) begin
               state_in = SEQ_RESULT;
            end
         end
         SEQ_RESULT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_min_in     = snap_min_ff;
               rsp_max_in     = snap_max_ff;
               rsp_rms_in     = dsq_root[SAMPLE_BITS-1:0];
               rsp_blk_in     = snap_blk_ff;
               rsp_partial_in = snap_partial_ff;
               state_in       = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         mode_ff      <= 1'b0;
         min_ff       <= MIN_INIT;
         max_ff       <= MAX_INIT;
         sum_ff       <= '0;
         count_ff     <= '0;
         blk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         blk_ff       <= blk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff       <= sample_in;
      eob_ff          <= eob_in;
      sq_ff           <= sq_in;
      snap_min_ff     <= snap_min_in;
      snap_max_ff     <= snap_max_in;
      snap_blk_ff     <= snap_blk_in;
      snap_partial_ff <= snap_partial_in;
      rsp_min_ff      <= rsp_min_in;
      rsp_max_ff      <= rsp_max_in;
      rsp_rms_ff      <= rsp_rms_in;
      rsp_blk_ff      <= rsp_blk_in;
      rsp_partial_ff  <= rsp_partial_in;
   end

   bmmrs_divsqrt u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (dsq_start),
      .dividend (dsq_dividend),
      .divisor  (count_ff),
      .status   (dsq_status),
      .root     (dsq_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_blk_ff, rsp_rms_ff, rsp_max_ff, rsp_min_ff});
   assign rsp_tuser  = rsp_partial_ff;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for block_min_max_rms_summary_core: random and directed samples,
// a built-in predictor of min, max, RMS and block index. Depends on bmmrs_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
   import bmmrs_pkg::*;

   localparam int SW             = SAMPLE_BITS_DEF;
   localparam int REQ_W          = ((SW + 7) / 8) * 8;
   localparam int RSP_W          = ((3 * SW + BLK_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES  = 8;     // margin for a sample with no summary to retire
   localparam int DRAIN_CYCLES   = 150;   // margin for the divide and root to finish
   localparam int MAX_REPORTS    = 10;

   localparam logic [SW-1:0] MOST_POS = {1'b0, {(SW - 1) {1'b1}}};
   localparam logic [SW-1:0] MOST_NEG = {1'b1, {(SW - 1) {1'b0}}};

   typedef struct {
      logic signed [SW-1:0]       min_value;
      logic signed [SW-1:0]       max_value;
      logic [SW-1:0]              rms_value;
      logic [BLK_BITS-1:0]        block_number;
      logic                       is_partial;
   } summary_type;

   // Predicts the summaries from accepted samples and checks the ones the core emits.
   class summary_scoreboard;
      bit                   large_mode;
      logic signed [SW-1:0] run_min;
      logic signed [SW-1:0] run_max;
      bit [63:0]            square_sum;
      int unsigned          fill;
      bit [BLK_BITS-1:0]    block_index;
      summary_type          pending_summaries[$];
      int                   mismatch_count;

      function new();
         large_mode = 1'b0;
         clear_block();
         block_index = '0;
         mismatch_count = 0;
      endfunction

      function void clear_block();
         run_min = MOST_POS;
         run_max = MOST_NEG;
         square_sum = '0;
         fill = 0;
      endfunction

      function int unsigned block_size();
         return large_mode ? int'(LARGE_BLOCK) : int'(SMALL_BLOCK);
      endfunction

      function int pending();
         return pending_summaries.size();
      endfunction

      // A different block size restarts everything; the same one is a no-op.
      function void set_mode(bit m);
         if (m != large_mode) begin
            large_mode = m;
            clear_block();
            block_index = '0;
         end
      endfunction

      // Floor square root, one result bit at a time from the top.
      function logic [SW-1:0] floor_root(bit [63:0] v);
         bit [31:0] root;
         bit [63:0] trial;
         root = '0;
         for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, root | (32'd1 << b)};
            if (trial * trial <= v) root = trial[31:0];
         end
         return SW'(root);
      endfunction

      function void note_sample(logic signed [SW-1:0] s, bit eob, bit rst);
         longint      mag;
         bit [63:0]   sq;
         bit          full;
         summary_type want;
         if (rst) begin
            clear_block();
            block_index = '0;
         end
         if (s < run_min) run_min = s;
         if (s > run_max) run_max = s;
         mag = s;
         if (mag < 0) mag = -mag;
         sq = 64'(mag) * 64'(mag);
         // saturate rather than wrap; only reachable with wide samples
         if (square_sum > ~sq) square_sum = '1;
         else square_sum = square_sum + sq;
         fill++;
         full = (fill >= block_size());
         if (!full && !eob) return;
         want.min_value    = run_min;
         want.max_value    = run_max;
         want.rms_value    = floor_root(square_sum / 64'(fill));
         want.block_number = block_index;
         want.is_partial   = !full;
         pending_summaries.push_back(want);
         if (full) begin
            clear_block();
            block_index++;
         end
      endfunction

      function void report(string field, longint want, longint got);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_summary(summary_type got);
         summary_type want;
         if (pending_summaries.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("mismatch: summary min %0d max %0d rms %0d block %0d with none due",
                        got.min_value, got.max_value, got.rms_value, got.block_number);
            return;
         end
         want = pending_summaries.pop_front();
         if (got.min_value !== want.min_value)
            report("min_value", want.min_value, got.min_value);
         if (got.max_value !== want.max_value)
            report("max_value", want.max_value, got.max_value);
         if (got.rms_value !== want.rms_value)
            report("rms_value", want.rms_value, got.rms_value);
         if (got.block_number !== want.block_number)
            report("block_number", want.block_number, got.block_number);
         if (got.is_partial !== want.is_partial)
            report("is_partial", want.is_partial, got.is_partial);
      endfunction

      // Any summary still owed at the end is a failure.
      function void close_out();
         if (pending_summaries.size() != 0) begin
            mismatch_count += pending_summaries.size();
            $display("mismatch: %0d summaries never arrived", pending_summaries.size());
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;   // [SW-1:0] sample
   logic               req_tlast = 1'b0; // end_of_buffer
   logic               req_tuser = 1'b0; // restart
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;        // min, max, rms, block_number from bit 0 up
   logic               rsp_tuser;        // is_partial
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_data = 1'b0;  // summary_mode

   summary_scoreboard  sb = new();
   summary_type        rsp_seen;
   int                 send_idle_pct = 13;
   int                 recv_idle_pct = 60;

   block_min_max_rms_summary_core #(
      .SAMPLE_BITS (SW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: check each summary transaction, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen.min_value    = rsp_tdata[SW-1:0];
         rsp_seen.max_value    = rsp_tdata[2*SW-1:SW];
         rsp_seen.rms_value    = rsp_tdata[3*SW-1:2*SW];
         rsp_seen.block_number = rsp_tdata[3*SW+BLK_BITS-1:3*SW];
         rsp_seen.is_partial   = rsp_tuser;
         sb.check_summary(rsp_seen);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Present one sample, hold it until accepted, then maybe idle the sender.
   task automatic send_sample(logic [SW-1:0] s, bit eob, bit rst);
      int gap;
      req_tdata  <= REQ_W'(s);
      req_tlast  <= eob;
      req_tuser  <= rst;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_sample($signed(s), eob, rst);
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain every owed summary, let the last silent sample retire, then write the mode.
   task automatic write_mode(bit m);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_data  <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_mode(m);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [SW-1:0] pick_sample();
      case ($urandom_range(7))
         0: return MOST_POS;
         1: return MOST_NEG;
         2: return SW'($urandom_range(255));
         3: return SW'(-int'($urandom_range(256, 1)));
         default: return SW'($urandom);
      endcase
   endfunction

   // Random samples; odds are one in N, and zero restart odds mean never.
   task automatic run_items(int n, int eob_odds, int rst_odds);
      logic [SW-1:0] s;
      bit            eob;
      bit            rst;
      repeat (n) begin
         s   = pick_sample();
         rst = (rst_odds != 0) && ($urandom_range(rst_odds - 1) == 0);
         eob = ($urandom_range(eob_odds - 1) == 0);
         // often flag end of buffer on the sample that fills the block
         if (!rst && sb.fill + 1 == sb.block_size()) eob = $urandom_range(1);
         send_sample(s, eob, rst);
      end
   endtask

   initial begin
      int guard;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, restart, partial summaries in the small block size.
      send_sample(MOST_POS, 1'b1, 1'b0);
      send_sample(MOST_NEG, 1'b1, 1'b0);
      send_sample(SW'(0), 1'b1, 1'b1);
      send_sample(MOST_NEG, 1'b1, 1'b1);
      send_sample(MOST_NEG, 1'b1, 1'b0);
      send_sample(SW'(1), 1'b0, 1'b1);
      send_sample(SW'(-1), 1'b0, 1'b0);
      send_sample(SW'(24'h2AAAAA), 1'b0, 1'b0);
      send_sample(SW'(24'hD55555), 1'b0, 1'b0);
      send_sample(MOST_POS, 1'b1, 1'b0);
      send_sample(SW'(3), 1'b1, 1'b0);
      send_sample(SW'(0), 1'b0, 1'b1);
      send_sample(SW'(0), 1'b1, 1'b0);

      // Same mode again must leave the running block alone; run past one full block.
      write_mode(1'b0);
      run_items(280, 16, 0);

      send_idle_pct = 60;
      recv_idle_pct = 13;
      write_mode(1'b1);
      run_items(200, 8, 64);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_mode(1'b0);
      run_items(160, 16, 64);

      // Same large mode twice, then a few samples in it.
      write_mode(1'b1);
      write_mode(1'b1);
      run_items(4, 2, 0);

      req_tvalid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
